// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; tsrs_dp includes them.
// Each macro expects signals named clk and rst in the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(lbl, ante, cons, msg)

`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrs_pkg
// Types, sizes and codes shared by the totient square range sum modules.
// ----------------------------------------------------------------------------
package tsrs_pkg;

  localparam int MAX_N   = 65536;
  localparam int FIELD_W = 17;
  // Table address width and counter width (counters must hold up to 2 * MAX_N).
  localparam int AW      = $clog2(MAX_N + 1);
  localparam int CW      = AW + 1;
  localparam int CMPW    = (FIELD_W > CW) ? FIELD_W : CW;
  localparam int SUM_W   = 64;
  localparam int DCNT_W  = $clog2(AW + 1);

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_BUILT = 2'd1,
    ST_BAD_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT_WR,
    CMD_P_RD,
    CMD_P_NEXT,
    CMD_M_SET,
    CMD_M_RD,
    CMD_DIV_START,
    CMD_M_WR,
    CMD_PRE_START,
    CMD_Z_WR,
    CMD_N_RD,
    CMD_SQ,
    CMD_ACC_WR,
    CMD_BUILD_DONE,
    CMD_Q_HI
  } dp_op_t;

  // Query steps and the output load share the same command field.
  typedef enum logic [1:0] {
    QCMD_NONE,
    QCMD_LO,
    QCMD_SUB,
    QCMD_OUT
  } dp_qop_t;

  typedef struct packed {
    dp_op_t  op;
    dp_qop_t qop;
  } dp_cmd_t;

  typedef struct packed {
    logic in_build;
    logic q_err;
    logic n_gt_lim;
    logic n_lt2;
    logic p_gt_lim;
    logic m_gt_lim;
    logic is_prime;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_PSCAN,
    S_PCHK,
    S_MRD,
    S_MDIV,
    S_MWAIT,
    S_ZERO,
    S_PRD,
    S_PSQ,
    S_PACC,
    S_QHI,
    S_QLO,
    S_QSUB,
    S_DONE
  } ctrl_state_t;

endpackage

// ===== rtl/tsrs_div.sv =====
// ----------------------------------------------------------------------------
// tsrs_div
// Restoring divider, one quotient bit per cycle, done pulses after AW steps.
// ----------------------------------------------------------------------------
module tsrs_div
  import tsrs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [AW-1:0] divisor,
  output logic [AW-1:0] quotient,
  output logic          busy,
  output logic          done
);

  logic [AW:0]       rem;
  logic [AW-1:0]     quo;
  logic [DCNT_W-1:0] cnt;
  logic [AW:0]       shifted;
  logic              fits;

  assign shifted  = {rem[AW-1:0], quo[AW-1]};
  assign fits     = (shifted >= {1'b0, divisor});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(AW);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? (shifted - {1'b0, divisor}) : shifted;
        quo <= {quo[AW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tsrs_dp.sv =====
// ----------------------------------------------------------------------------
// tsrs_dp
// Datapath: table memory, sieve counters, divider, prefix accumulator,
// query subtract and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsrs_dp
  import tsrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               opcode,
  input  logic [FIELD_W-1:0] range_low,
  input  logic [FIELD_W-1:0] range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   range_sum,
  output logic [1:0]         status
);

  logic [SUM_W-1:0]   mem [0:MAX_N];
  logic [SUM_W-1:0]   rdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [SUM_W-1:0]   wr_data;

  logic [FIELD_W-1:0] build_limit;
  logic [AW-1:0]      lim;
  logic [AW-1:0]      built_limit;
  logic               table_ready;
  logic [FIELD_W-1:0] lo;
  logic [FIELD_W-1:0] hi;
  logic [CW-1:0]      n;
  logic [CW-1:0]      p;
  logic [CW-1:0]      m;
  logic [AW-1:0]      val;
  logic [2*AW-1:0]    sq;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   hi_val;
  logic [SUM_W-1:0]   res_sum;
  status_t            res_status;
  status_t            out_status;
  logic [AW-1:0]      lim_next;
  logic               range_bad;
  logic [SUM_W-1:0]   acc_next;
  logic [AW-1:0]      quotient;
  logic               div_busy;
  logic               div_done;
  logic               div_start;

  // Build limit is clamped to MAX_N, the last table address, and at least one.
  always_comb begin
    if (CMPW'(build_limit) > CMPW'(MAX_N)) begin
      lim_next = AW'(MAX_N);
    end else if (build_limit == '0) begin
      lim_next = AW'(1);
    end else begin
      lim_next = AW'(build_limit);
    end
  end

  assign range_bad = (lo == '0) || (lo > hi) || (CMPW'(hi) > CMPW'(built_limit));
  assign acc_next  = acc + SUM_W'(sq);
  assign div_start = (cmd.op == CMD_DIV_START);

  assign stat.in_build = (opcode == OP_BUILD);
  assign stat.q_err    = !table_ready || range_bad;
  assign stat.n_gt_lim = (n > CW'(lim));
  assign stat.n_lt2    = (n < CW'(2));
  assign stat.p_gt_lim = (p > CW'(lim));
  assign stat.m_gt_lim = (m > CW'(lim));
  assign stat.is_prime = (rdata == SUM_W'(p));
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

  tsrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rdata[AW-1:0]),
    .divisor  (p[AW-1:0]),
    .quotient (quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = n[AW-1:0];
    wr_data = '0;
    case (cmd.op)
      CMD_P_RD: begin
        rd_en   = 1'b1;
        rd_addr = p[AW-1:0];
      end
      CMD_M_RD: begin
        rd_en   = 1'b1;
        rd_addr = m[AW-1:0];
      end
      CMD_N_RD: begin
        rd_en   = 1'b1;
        rd_addr = n[AW-1:0];
      end
      CMD_Q_HI: begin
        rd_en   = !(!table_ready || range_bad);
        rd_addr = AW'(hi);
      end
      CMD_INIT_WR: begin
        wr_en   = 1'b1;
        wr_data = SUM_W'(n);
      end
      CMD_M_WR: begin
        wr_en   = 1'b1;
        wr_addr = m[AW-1:0];
        wr_data = SUM_W'(val - quotient);
      end
      CMD_Z_WR: begin
        wr_en = 1'b1;
      end
      CMD_ACC_WR: begin
        wr_en   = 1'b1;
        wr_data = acc_next;
      end
      default: begin
      end
    endcase
    if (cmd.qop == QCMD_LO) begin
      rd_en   = 1'b1;
      rd_addr = AW'(lo - FIELD_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      build_limit <= FIELD_W'(65536);
      table_ready <= 1'b0;
      built_limit <= '0;
    end else begin
      if (cfg_we) begin
        build_limit <= cfg_wdata;
      end
      if (cmd.op == CMD_BUILD_DONE) begin
        table_ready <= 1'b1;
        built_limit <= lim;
      end
    end
  end

  // Sieve, prefix and query registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        lo  <= range_low;
        hi  <= range_high;
        lim <= lim_next;
        n   <= '0;
        p   <= CW'(2);
      end
      CMD_INIT_WR:   n <= n + 1'b1;
      CMD_P_NEXT:    p <= p + 1'b1;
      CMD_M_SET:     m <= p;
      CMD_DIV_START: val <= rdata[AW-1:0];
      CMD_M_WR:      m <= m + p;
      CMD_PRE_START: begin
        n   <= '0;
        acc <= '0;
      end
      CMD_Z_WR:      n <= n + 1'b1;
      CMD_SQ:        sq <= rdata[AW-1:0] * rdata[AW-1:0];
      CMD_ACC_WR: begin
        acc <= acc_next;
        n   <= n + 1'b1;
      end
      CMD_BUILD_DONE: begin
        res_sum    <= '0;
        res_status <= ST_OK;
      end
      CMD_Q_HI: begin
        res_sum <= '0;
        if (!table_ready) begin
          res_status <= ST_NOT_BUILT;
        end else if (range_bad) begin
          res_status <= ST_BAD_RANGE;
        end else begin
          res_status <= ST_OK;
        end
      end
      default: begin
      end
    endcase
    case (cmd.qop)
      QCMD_LO:  hi_val <= rdata;
      QCMD_SUB: res_sum <= hi_val - rdata;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.qop == QCMD_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.qop == QCMD_OUT) begin
      range_sum  <= res_sum;
      out_status <= res_status;
    end
  end

  assign status = out_status;

  `ASSERT_IMPLY(a_err_zero_sum, out_valid && (out_status != ST_OK), range_sum == '0,
                "error item carries a nonzero sum")
  `ASSERT_IMPLY(a_div_idle_on_start, div_start, !div_busy, "divider restarted while busy")
  `ASSERT_IMPLY(a_lo_read_ready, cmd.qop == QCMD_LO, table_ready && !range_bad,
                "table read for a query that should have failed")

endmodule

// ===== rtl/tsrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsrs_ctrl
// Controller: sequences the build sweeps and the query steps.
// ----------------------------------------------------------------------------
module tsrs_ctrl
  import tsrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_build ? S_INIT : S_QHI;
        end
      end
      S_INIT: begin
        if (stat.n_gt_lim) begin
          state_next = S_PSCAN;
        end
      end
      S_PSCAN: state_next = stat.p_gt_lim ? S_ZERO : S_PCHK;
      S_PCHK:  state_next = stat.is_prime ? S_MRD : S_PSCAN;
      S_MRD:   state_next = stat.m_gt_lim ? S_PSCAN : S_MDIV;
      S_MDIV:  state_next = S_MWAIT;
      S_MWAIT: begin
        if (stat.div_done) begin
          state_next = S_MRD;
        end
      end
      S_ZERO: begin
        if (!stat.n_lt2) begin
          state_next = S_PRD;
        end
      end
      S_PRD:   state_next = stat.n_gt_lim ? S_DONE : S_PSQ;
      S_PSQ:   state_next = S_PACC;
      S_PACC:  state_next = S_PRD;
      S_QHI:   state_next = stat.q_err ? S_DONE : S_QLO;
      S_QLO:   state_next = S_QSUB;
      S_QSUB:  state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = CMD_NONE;
    cmd.qop  = QCMD_NONE;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = CMD_LOAD;
        end
      end
      S_INIT: begin
        if (!stat.n_gt_lim) begin
          cmd.op = CMD_INIT_WR;
        end
      end
      S_PSCAN: cmd.op = stat.p_gt_lim ? CMD_PRE_START : CMD_P_RD;
      S_PCHK:  cmd.op = stat.is_prime ? CMD_M_SET : CMD_P_NEXT;
      S_MRD:   cmd.op = stat.m_gt_lim ? CMD_P_NEXT : CMD_M_RD;
      S_MDIV:  cmd.op = CMD_DIV_START;
      S_MWAIT: begin
        if (stat.div_done) begin
          cmd.op = CMD_M_WR;
        end
      end
      S_ZERO: begin
        if (stat.n_lt2) begin
          cmd.op = CMD_Z_WR;
        end
      end
      S_PRD:   cmd.op = stat.n_gt_lim ? CMD_BUILD_DONE : CMD_N_RD;
      S_PSQ:   cmd.op = CMD_SQ;
      S_PACC:  cmd.op = CMD_ACC_WR;
      S_QHI:   cmd.op = CMD_Q_HI;
      S_QLO:   cmd.qop = QCMD_LO;
      S_QSUB:  cmd.qop = QCMD_SUB;
      S_DONE: begin
        if (stat.out_free) begin
          cmd.qop = QCMD_OUT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/totient_square_range_sum_core.sv =====
// ----------------------------------------------------------------------------
// totient_square_range_sum_core
// Builds a table of prefix sums of phi(n)^2 and answers range sum queries.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid/in_stall    opcode, range_low, range_high
//  output    out_valid/out_stall  range_sum, status
//  config    cfg_we               cfg_wdata (build_limit)
//
// A query passes through S_QHI, S_QLO and S_QSUB, and its result is loaded into
// the output register in S_DONE; a query that fails its checks goes from S_QHI
// straight to S_DONE. A query's two table reads share the single read port.
// In a build, each multiple of each prime waits for the bit-serial divider.
// Reset clears the ready flag, out_valid and the controller state and sets
// build_limit to 65536; the table memory is not cleared.
// The input is stalled while an item is in work; a stalled result waits in
// the output register while the next item may be accepted.
module totient_square_range_sum_core
  import tsrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [FIELD_W-1:0] range_low,
  input  logic [FIELD_W-1:0] range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   range_sum,
  output logic [1:0]         status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsrs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (opcode),
    .range_low  (range_low),
    .range_high (range_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .range_sum  (range_sum),
    .status     (status)
  );

endmodule
